>>> sv/lobm_pkg.sv
// Shared constants, types and helpers for the limit order book matcher.
package lobm_pkg;
  localparam int NUM_LEVELS  = 256;
  localparam int LEVEL_DEPTH = 8;
  localparam int MAX_TRADES  = 63;
  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int POS_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W = LVL_W + POS_W;
  localparam int TRD_W  = $clog2(MAX_TRADES + 1);

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PLACED   = 2'd0;
  localparam kind_t KIND_REJECTED = 2'd1;
  localparam kind_t KIND_TRADE    = 2'd2;
  localparam kind_t KIND_DONE     = 2'd3;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] qty;
  } slot_t;

  // Queue head and fill count of one price level.
  typedef struct packed {
    logic [POS_W-1:0] head;
    logic [CNT_W-1:0] cnt;
  } lptr_t;

  // The search result bundle passed from the search unit to the controller.
  typedef struct packed {
    logic             bid_ok;
    logic [LVL_W-1:0] bid;
    logic             ask_ok;
    logic [LVL_W-1:0] ask;
  } best_t;

  function automatic logic [POS_W-1:0] wrap_pos(input logic [POS_W:0] v);
    logic [POS_W:0] d;
    d = (POS_W+1)'(LEVEL_DEPTH);
    return (v >= d) ? POS_W'(v - d) : v[POS_W-1:0];
  endfunction
endpackage

>>> sv/limit_order_book_matcher.sv
// Top level of the limit order book matcher: command sequencer and level state.
// A command beat is taken when start is high and busy is low. A place command
// (in_command 0) queues an order at the tail of its price level and returns one
// result: placed or rejected, with the order id. A match command (in_command 1)
// crosses the best bid against the best ask and returns one trade result per
// fill, then a match-done result that flags whether the book still crosses
// after the trade cap. Each result beat shows on the out_ ports for one cycle
// with out_valid high; out_last marks the final beat of a command. The receiver
// cannot stall, so no result is ever held back.
// A place result passes through pointer read, slot and pointer write, the
// settling of the best-level search, then the result register. A match
// looks at the book in the cycle after its beat; a match that finds nothing
// to cross returns only its done beat. Each trade runs through pointer read,
// slot read, write back and search; its trade beat goes out once the next
// search has settled, and the done beat directly follows the last trade beat.
// busy drops in the cycle of the final result, so the next command can be
// taken at the edge that takes that result. Reset clears the id counter and
// the occupancy bits; a level whose occupancy bit is clear reads as an empty
// queue starting at slot zero, so the memories are never cleared.
module limit_order_book_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [7:0]  in_price_tick,
  input  logic [15:0] in_quantity,
  input  logic        in_is_buy_side,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [31:0] out_order_id,
  output logic [15:0] out_trade_qty,
  output logic [7:0]  out_trade_price,
  output logic [31:0] out_buy_order_id,
  output logic [31:0] out_sell_order_id,
  output logic        out_more_pending,
  output logic        out_last,
  output logic        out_mid_valid,
  output logic [8:0]  out_mid_twice
);
  import lobm_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PRD   = 9'b000000010,
    S_PWAIT = 9'b000000100,
    S_PEMIT = 9'b000001000,
    S_DEC   = 9'b000010000,
    S_PTR   = 9'b000100000,
    S_SLOT  = 9'b001000000,
    S_MWAIT = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // One bit per nonempty level and side; these feed the best-level search.
  logic [NUM_LEVELS-1:0] bocc_r, socc_r;

  logic [31:0] next_id_r;
  logic [TRD_W-1:0] ntr_r;
  logic        buy_r;
  logic [7:0]  tick_r;
  logic [15:0] qty_r;
  logic        rej_r;
  logic [31:0] id_r;
  best_t       best;
  logic [LVL_W-1:0] b_r, a_r;
  // Pointers of the bid and ask levels that take part in the current trade.
  lptr_t       bp_r, sp_r;

  // Memory ports: slot memories (bs_, ss_) and level pointer memories (bp_, sp_).
  logic              bs_we, ss_we, bp_we, sp_we;
  logic [ADDR_W-1:0] bs_wa, ss_wa, bs_ra, ss_ra;
  logic [LVL_W-1:0]  bp_wa, sp_wa, bp_ra, sp_ra;
  slot_t             bs_wd, ss_wd, bs_rd, ss_rd;
  lptr_t             bp_wd, sp_wd, bp_rd, sp_rd;

  lobm_best u_best (.clk(clk), .buy_occ(bocc_r), .sell_occ(socc_r), .best(best));

  lobm_store #(.DW($bits(slot_t)), .AW(ADDR_W)) u_bstore (
    .clk(clk), .we(bs_we), .waddr(bs_wa), .wdata(bs_wd), .raddr(bs_ra), .rdata(bs_rd));
  lobm_store #(.DW($bits(slot_t)), .AW(ADDR_W)) u_sstore (
    .clk(clk), .we(ss_we), .waddr(ss_wa), .wdata(ss_wd), .raddr(ss_ra), .rdata(ss_rd));
  lobm_store #(.DW($bits(lptr_t)), .AW(LVL_W)) u_bptrs (
    .clk(clk), .we(bp_we), .waddr(bp_wa), .wdata(bp_wd), .raddr(bp_ra), .rdata(bp_rd));
  lobm_store #(.DW($bits(lptr_t)), .AW(LVL_W)) u_sptrs (
    .clk(clk), .we(sp_we), .waddr(sp_wa), .wdata(sp_wd), .raddr(sp_ra), .rdata(sp_rd));

  logic crossing;
  logic go;
  assign crossing = best.bid_ok && best.ask_ok && (best.bid >= best.ask);
  // Another trade is due while the book crosses and the cap is not reached.
  assign go = crossing && (ntr_r != TRD_W'(MAX_TRADES));
  assign busy = (state_r != S_IDLE);

  logic       mid_ok;
  logic [8:0] mid2;
  assign mid_ok = best.bid_ok && best.ask_ok;
  assign mid2 = mid_ok ? (9'(best.bid) + 9'(best.ask)) : 9'd0;

  // Place path. An empty level reads as head zero, count zero, whatever the
  // pointer memory still holds for it.
  logic [LVL_W-1:0] plv;
  logic             in_range;
  lptr_t            pl_ptr;
  logic [POS_W-1:0] ppos;
  logic             rej;
  assign plv = LVL_W'(tick_r);
  assign in_range = ({1'b0, tick_r} < 9'(NUM_LEVELS));
  assign pl_ptr = buy_r ? (bocc_r[plv] ? bp_rd : '0) : (socc_r[plv] ? sp_rd : '0);
  assign ppos = wrap_pos({1'b0, pl_ptr.head} + (POS_W+1)'(pl_ptr.cnt));
  assign rej = !in_range || (qty_r == 16'd0) || (pl_ptr.cnt >= CNT_W'(LEVEL_DEPTH));

  // Trade path: the smaller of the two head quantities moves.
  logic [15:0] tq;
  logic        bfill, sfill;
  assign tq = (bs_rd.qty < ss_rd.qty) ? bs_rd.qty : ss_rd.qty;
  assign bfill = (bs_rd.qty == tq);
  assign sfill = (ss_rd.qty == tq);

  always_comb begin
    bs_we = 1'b0; ss_we = 1'b0; bp_we = 1'b0; sp_we = 1'b0;
    bs_wa = {plv, ppos}; ss_wa = {plv, ppos};
    bs_wd.id = id_r; bs_wd.qty = qty_r; ss_wd = bs_wd;
    bp_wa = plv; sp_wa = plv;
    bp_wd.head = pl_ptr.head; bp_wd.cnt = pl_ptr.cnt + CNT_W'(1); sp_wd = bp_wd;
    // The command beat reads the pointers of its level; a match search
    // result reads the pointers of the best levels.
    bp_ra = LVL_W'(in_price_tick); sp_ra = LVL_W'(in_price_tick);
    bs_ra = {b_r, bp_rd.head};
    ss_ra = {a_r, sp_rd.head};
    if (state_r == S_PRD && !rej) begin
      bs_we = buy_r; ss_we = !buy_r;
      bp_we = buy_r; sp_we = !buy_r;
    end
    if (state_r == S_DEC) begin
      bp_ra = best.bid; sp_ra = best.ask;
    end
    if (state_r == S_SLOT) begin
      bs_we = 1'b1; ss_we = 1'b1;
      bs_wa = {b_r, bp_r.head}; ss_wa = {a_r, sp_r.head};
      bs_wd.id = bs_rd.id; bs_wd.qty = bs_rd.qty - tq;
      ss_wd.id = ss_rd.id; ss_wd.qty = ss_rd.qty - tq;
      // A filled head order leaves its queue.
      bp_we = bfill; sp_we = sfill;
      bp_wa = b_r; sp_wa = a_r;
      bp_wd.head = wrap_pos({1'b0, bp_r.head} + (POS_W+1)'(1));
      bp_wd.cnt  = bp_r.cnt - CNT_W'(1);
      sp_wd.head = wrap_pos({1'b0, sp_r.head} + (POS_W+1)'(1));
      sp_wd.cnt  = sp_r.cnt - CNT_W'(1);
    end
  end

  // Pending trade result, emitted when the following search completes so the
  // mid fields reflect the book after the trade.
  logic        pend_r;
  logic [15:0] ptq_r;
  logic [7:0]  ppr_r;
  logic [31:0] pbid_r, psid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = in_command ? S_DEC : S_PRD;
      S_PRD:   state_nxt = S_PWAIT;
      S_PWAIT: state_nxt = S_PEMIT;
      S_PEMIT: state_nxt = S_IDLE;
      S_DEC: begin
        if (go) state_nxt = S_PTR;
        else if (pend_r) state_nxt = S_DONE;
        else state_nxt = S_IDLE;
      end
      S_PTR:   state_nxt = S_SLOT;
      S_SLOT:  state_nxt = S_MWAIT;
      S_MWAIT: state_nxt = S_DEC;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      next_id_r <= '0;
      ntr_r     <= '0;
      pend_r    <= 1'b0;
      out_valid <= 1'b0;
      bocc_r    <= '0;
      socc_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            tick_r <= in_price_tick;
            qty_r  <= in_quantity;
            buy_r  <= in_is_buy_side;
            ntr_r  <= '0;
            pend_r <= 1'b0;
            if (!in_command) begin
              id_r      <= next_id_r;
              next_id_r <= next_id_r + 32'd1;
            end
          end
        end
        S_PRD: begin
          rej_r <= rej;
          if (!rej) begin
            if (buy_r) bocc_r[plv] <= 1'b1;
            else       socc_r[plv] <= 1'b1;
          end
        end
        S_PWAIT: begin
        end
        S_PEMIT: begin
          out_valid         <= 1'b1;
          out_kind          <= rej_r ? KIND_REJECTED : KIND_PLACED;
          out_order_id      <= id_r;
          out_trade_qty     <= '0;
          out_trade_price   <= '0;
          out_buy_order_id  <= '0;
          out_sell_order_id <= '0;
          out_more_pending  <= 1'b0;
          out_last          <= 1'b1;
          out_mid_valid     <= mid_ok;
          out_mid_twice     <= mid2;
        end
        S_DEC: begin
          b_r <= best.bid;
          a_r <= best.ask;
          out_valid     <= pend_r || !go;
          out_order_id  <= '0;
          out_mid_valid <= mid_ok;
          out_mid_twice <= mid2;
          if (pend_r) begin
            out_kind          <= KIND_TRADE;
            out_trade_qty     <= ptq_r;
            out_trade_price   <= ppr_r;
            out_buy_order_id  <= pbid_r;
            out_sell_order_id <= psid_r;
            out_more_pending  <= 1'b0;
            out_last          <= 1'b0;
            pend_r            <= 1'b0;
          end else begin
            out_kind          <= KIND_DONE;
            out_trade_qty     <= '0;
            out_trade_price   <= '0;
            out_buy_order_id  <= '0;
            out_sell_order_id <= '0;
            out_more_pending  <= crossing;
            out_last          <= 1'b1;
          end
        end
        S_PTR: begin
          bp_r <= bp_rd;
          sp_r <= sp_rd;
        end
        S_SLOT: begin
          ntr_r  <= ntr_r + TRD_W'(1);
          pend_r <= 1'b1;
          ptq_r  <= tq;
          ppr_r  <= 8'(a_r);
          pbid_r <= bs_rd.id;
          psid_r <= ss_rd.id;
          // A level whose last order fills becomes empty.
          if (bfill && bp_r.cnt == CNT_W'(1)) bocc_r[b_r] <= 1'b0;
          if (sfill && sp_r.cnt == CNT_W'(1)) socc_r[a_r] <= 1'b0;
        end
        S_MWAIT: begin
        end
        S_DONE: begin
          // The book has not changed since the last trade beat.
          out_valid         <= 1'b1;
          out_kind          <= KIND_DONE;
          out_order_id      <= '0;
          out_trade_qty     <= '0;
          out_trade_price   <= '0;
          out_buy_order_id  <= '0;
          out_sell_order_id <= '0;
          out_more_pending  <= crossing;
          out_last          <= 1'b1;
          out_mid_valid     <= mid_ok;
          out_mid_twice     <= mid2;
        end
        default: begin
        end
      endcase
    end
  end
endmodule

>>> sv/lobm_best.sv
// Best bid and best ask search over the occupancy bit vectors.
module lobm_best (
  input  logic                           clk,
  input  logic [lobm_pkg::NUM_LEVELS-1:0] buy_occ,
  input  logic [lobm_pkg::NUM_LEVELS-1:0] sell_occ,
  output lobm_pkg::best_t                best
);
  import lobm_pkg::*;
  best_t best_nxt;

  always_comb begin
    best_nxt = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (buy_occ[i]) begin
        best_nxt.bid_ok = 1'b1;
        best_nxt.bid = LVL_W'(i);
      end
    end
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (sell_occ[i]) begin
        best_nxt.ask_ok = 1'b1;
        best_nxt.ask = LVL_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    best <= best_nxt;
  end
endmodule

>>> sv/lobm_store.sv
// Generic synchronous RAM: one write port and one read port with registered data.
module lobm_store #(
  parameter int DW = 48,
  parameter int AW = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sim/limit_order_book_matcher_checker.sv
// Checker for the limit order book matcher: book prediction and result comparison.
module limit_order_book_matcher_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_command,
  input  logic [7:0]  in_price_tick,
  input  logic [15:0] in_quantity,
  input  logic        in_is_buy_side,
  input  logic        out_valid,
  input  logic [1:0]  out_kind,
  input  logic [31:0] out_order_id,
  input  logic [15:0] out_trade_qty,
  input  logic [7:0]  out_trade_price,
  input  logic [31:0] out_buy_order_id,
  input  logic [31:0] out_sell_order_id,
  input  logic        out_more_pending,
  input  logic        out_last,
  input  logic        out_mid_valid,
  input  logic [8:0]  out_mid_twice,
  output int          fail_count,
  output int          results_owed,
  output int          trade_count,
  output int          reject_count,
  output int          capped_count
);
  import lobm_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] order_id;
    logic [15:0] trade_qty;
    logic [7:0]  trade_price;
    logic [31:0] buy_id;
    logic [31:0] sell_id;
    logic        more;
    logic        last;
    logic        mid_ok;
    logic [8:0]  mid2;
  } book_result_t;

  // Index 1 is the buy side, index 0 the sell side.
  logic [31:0] rest_id  [2][NUM_LEVELS][LEVEL_DEPTH];
  logic [15:0] rest_qty [2][NUM_LEVELS][LEVEL_DEPTH];
  int          lvl_head [2][NUM_LEVELS];
  int          lvl_count[2][NUM_LEVELS];
  logic [31:0] id_ctr;
  book_result_t owed_q[$];

  function automatic int best_bid();
    for (int lv = NUM_LEVELS - 1; lv >= 0; lv--)
      if (lvl_count[1][lv] > 0) return lv;
    return -1;
  endfunction

  function automatic int best_ask();
    for (int lv = 0; lv < NUM_LEVELS; lv++)
      if (lvl_count[0][lv] > 0) return lv;
    return -1;
  endfunction

  // Queues one result; the mid fields reflect the book as it now stands.
  function automatic void owe(kind_t k, logic [31:0] oid, logic [15:0] q, logic [7:0] p,
                              logic [31:0] bid_id, logic [31:0] ask_id, logic more,
                              logic lst);
    book_result_t r;
    int b;
    int a;
    b = best_bid();
    a = best_ask();
    r = '{k, oid, q, p, bid_id, ask_id, more, lst, 1'b0, 9'd0};
    if (b >= 0 && a >= 0) begin
      r.mid_ok = 1'b1;
      r.mid2 = 9'(b + a);
    end
    owed_q.push_back(r);
  endfunction

  function automatic void take_head(int side, int lv);
    lvl_head[side][lv] = (lvl_head[side][lv] + 1) % LEVEL_DEPTH;
    lvl_count[side][lv]--;
  endfunction

  function automatic void predict_place(logic [7:0] tick, logic [15:0] qty, logic buy);
    int s;
    int pos;
    logic [31:0] id;
    s = buy ? 1 : 0;
    id = id_ctr;
    id_ctr = id_ctr + 32'd1;
    if (qty == 0 || lvl_count[s][tick] >= LEVEL_DEPTH) begin
      reject_count++;
      owe(KIND_REJECTED, id, 16'd0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b1);
    end else begin
      pos = (lvl_head[s][tick] + lvl_count[s][tick]) % LEVEL_DEPTH;
      rest_id[s][tick][pos] = id;
      rest_qty[s][tick][pos] = qty;
      lvl_count[s][tick]++;
      owe(KIND_PLACED, id, 16'd0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b1);
    end
  endfunction

  function automatic void predict_match();
    int n;
    int b;
    int a;
    int bh;
    int ah;
    bit crossing;
    logic [15:0] q;
    logic [31:0] bid_id;
    logic [31:0] ask_id;
    n = 0;
    forever begin
      b = best_bid();
      a = best_ask();
      crossing = (b >= 0 && a >= 0 && b >= a);
      if (!crossing || n >= MAX_TRADES) break;
      bh = lvl_head[1][b];
      ah = lvl_head[0][a];
      q = (rest_qty[1][b][bh] < rest_qty[0][a][ah]) ? rest_qty[1][b][bh] : rest_qty[0][a][ah];
      bid_id = rest_id[1][b][bh];
      ask_id = rest_id[0][a][ah];
      rest_qty[1][b][bh] -= q;
      rest_qty[0][a][ah] -= q;
      if (rest_qty[1][b][bh] == 0) take_head(1, b);
      if (rest_qty[0][a][ah] == 0) take_head(0, a);
      owe(KIND_TRADE, 32'd0, q, 8'(a), bid_id, ask_id, 1'b0, 1'b0);
      trade_count++;
      n++;
    end
    if (crossing) capped_count++;
    owe(KIND_DONE, 32'd0, 16'd0, 8'd0, 32'd0, 32'd0, crossing, 1'b1);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  assign results_owed = owed_q.size();

  always @(posedge clk) begin
    book_result_t e;
    if (!rst_n) begin
      for (int s = 0; s < 2; s++)
        for (int lv = 0; lv < NUM_LEVELS; lv++) begin
          lvl_head[s][lv] = 0;
          lvl_count[s][lv] = 0;
        end
      id_ctr = '0;
      owed_q.delete();
      fail_count = 0;
      trade_count = 0;
      reject_count = 0;
      capped_count = 0;
    end else begin
      // Results are compared before a new command is predicted; a command
      // accepted on this edge cannot have a result on the same edge.
      if (out_valid) begin
        if (owed_q.size() == 0) begin
          $error("result beat with nothing expected: kind %0d", out_kind);
          fail_count++;
        end else begin
          e = owed_q.pop_front();
          check_field("kind", 32'(e.kind), 32'(out_kind));
          check_field("order_id", e.order_id, out_order_id);
          check_field("trade_qty", 32'(e.trade_qty), 32'(out_trade_qty));
          check_field("trade_price", 32'(e.trade_price), 32'(out_trade_price));
          check_field("buy_order_id", e.buy_id, out_buy_order_id);
          check_field("sell_order_id", e.sell_id, out_sell_order_id);
          check_field("more_pending", 32'(e.more), 32'(out_more_pending));
          check_field("last", 32'(e.last), 32'(out_last));
          check_field("mid_valid", 32'(e.mid_ok), 32'(out_mid_valid));
          check_field("mid_twice", 32'(e.mid2), 32'(out_mid_twice));
        end
      end
      if (start && !busy) begin
        if (in_command) predict_match();
        else predict_place(in_price_tick, in_quantity, in_is_buy_side);
      end
    end
  end

endmodule

>>> sim/limit_order_book_matcher_tb.sv
// Testbench top for the limit order book matcher: stimulus, watchdog and verdict.
module limit_order_book_matcher_tb;
  import lobm_pkg::*;

  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_MATCH = 1'b1;
  localparam int   STALL_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic [7:0]  in_price_tick;
  logic [15:0] in_quantity;
  logic        in_is_buy_side;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [31:0] out_order_id;
  logic [15:0] out_trade_qty;
  logic [7:0]  out_trade_price;
  logic [31:0] out_buy_order_id;
  logic [31:0] out_sell_order_id;
  logic        out_more_pending;
  logic        out_last;
  logic        out_mid_valid;
  logic [8:0]  out_mid_twice;

  int fail_count;
  int results_owed;
  int trade_count;
  int reject_count;
  int capped_count;
  int sent_count;
  int idle_cycles;

  limit_order_book_matcher i_dut (.*);

  limit_order_book_matcher_checker i_checker (.*);

  // Free-running clock with a 20 unit period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // The watchdog counts edges at which no beat moves on either channel. The
  // longest correct silence while commands are sent is the largest sender gap
  // plus the wait for the first result of a match, and the limit sits well
  // above that.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("limit_order_book_matcher_tb: errors");
        $finish;
      end
    end
  end

  // Sends one command beat. The sender first idles for the given number of
  // cycles; start is only dropped when there is a gap, so back-to-back beats
  // never see start lowered and raised within one time step. The task returns
  // on the edge at which the beat is taken.
  task automatic send_beat(logic cmd, logic [7:0] tick, logic [15:0] qty, logic buy,
                           int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_price_tick <= tick;
    in_quantity <= qty;
    in_is_buy_side <= buy;
    do @(posedge clk); while (busy);
    sent_count++;
  endtask

  task automatic queue_order(logic [7:0] tick, logic [15:0] qty, logic buy, int gap);
    send_beat(CMD_PLACE, tick, qty, buy, gap);
  endtask

  // A match beat carries random junk in the fields it ignores.
  task automatic run_match(int gap);
    send_beat(CMD_MATCH, 8'($urandom), 16'($urandom), 1'($urandom), gap);
  endtask

  // Gaps come in stretches: some runs of beats go back to back, others draw
  // a fresh random wait for each beat.
  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  initial begin
    bit burst;
    int lv;
    bit buy;
    logic [15:0] qty;
    sent_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_PLACE;
    in_price_tick = '0;
    in_quantity = '0;
    in_is_buy_side = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A match on an empty book finds nothing to cross.
    run_match(0);
    // Field extremes: the top and bottom ticks, full-scale and unit sizes.
    queue_order(8'd255, 16'hFFFF, 1'b1, 0);
    queue_order(8'd0, 16'd1, 1'b0, 2);
    // A zero-size order is turned away but still uses up an id.
    queue_order(8'd10, 16'd0, 1'b1, 0);
    queue_order(8'd0, 16'hFFFF, 1'b0, 1);
    // Fill one bid level and push one past its depth to see the level-full reject.
    for (int i = 0; i <= LEVEL_DEPTH; i++) queue_order(8'd1, 16'(i + 1), 1'b1, 0);
    // Crossing match: partial fills shrink the resting order instead of copying it.
    run_match(3);
    queue_order(8'd254, 16'h5555, 1'b0, 0);
    queue_order(8'd254, 16'hAAAA, 1'b1, 0);
    run_match(0);
    run_match(0);

    // Trade cap: build many unit orders on both sides so that one match hits
    // the cap while the book still crosses, then drain the rest.
    for (int i = 0; i < 72; i++) begin
      queue_order(8'(120 + i % 8), 16'd1, 1'b1, 0);
      queue_order(8'(100 + i % 8), 16'd1, 1'b0, 0);
    end
    run_match(0);
    run_match(5);

    // Random part. Prices mostly sit in a narrow band so that the book keeps
    // crossing; now and then a tick or size spans the whole field.
    burst = 1'b0;
    for (int i = 0; i < 244; i++) begin
      if (i % 40 == 0) burst = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 15) begin
        run_match(draw_gap(burst));
      end else begin
        buy = 1'($urandom);
        if ($urandom_range(0, 9) == 0) lv = $urandom_range(0, 255);
        else lv = buy ? $urandom_range(118, 140) : $urandom_range(110, 132);
        case ($urandom_range(0, 9))
          0: qty = 16'($urandom);
          1: qty = 16'd0;
          default: qty = 16'($urandom_range(1, 300));
        endcase
        queue_order(8'(lv), qty, buy, draw_gap(burst));
      end
    end
    run_match(0);
    start <= 1'b0;

    // Drain, then give the block a further quiet window in which nothing may appear.
    while (results_owed > 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d command beats: %0d trades, %0d rejects, %0d capped matches.",
             sent_count, trade_count, reject_count, capped_count);
    if (fail_count == 0) begin
      $display("limit_order_book_matcher_tb: clean");
    end else begin
      $display("limit_order_book_matcher_tb: errors");
    end
    $finish;
  end

endmodule
